// ----- src/rtqi_pkg.sv -----
// Shared types, widths and latencies of the ray against triangle or quad face test.
`default_nettype none
package rtqi_pkg;

   // Fixed field widths
   localparam int PACK_BITS   = 63;
   localparam int HANDLE_BITS = 32;
   localparam int EPS_BITS    = 16;
   localparam int OUT_BITS    = 20;

   // Defaults of the top level parameters
   localparam int COORD_BITS_DEF       = 21;
   localparam int RESULT_FRAC_BITS_DEF = 16;

   // Reset value of the tolerance register
   localparam logic [EPS_BITS-1:0] EPS_RESET = 16'd1;

   // Register stages of each unit
   localparam int FRONT_LAT = 3;
   localparam int DOT_LAT   = 3;
   localparam int DIV_LAT   = OUT_BITS + 3;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_FIRST  = 2'd1,
      KIND_SECOND = 2'd2
   } hit_kind_type;

   typedef struct packed {
      logic [PACK_BITS-1:0]   ray_start;
      logic [PACK_BITS-1:0]   ray_dir;
      logic [PACK_BITS-1:0]   vertex_a;
      logic [PACK_BITS-1:0]   vertex_b;
      logic [PACK_BITS-1:0]   vertex_c;
      logic [PACK_BITS-1:0]   vertex_d;
      logic                   is_quad;
      logic [HANDLE_BITS-1:0] origin_object;
      logic [HANDLE_BITS-1:0] origin_face;
      logic [HANDLE_BITS-1:0] face_object;
      logic [HANDLE_BITS-1:0] face_handle;
   } req_type;

   typedef struct packed {
      hit_kind_type               hit_kind;
      logic signed [OUT_BITS-1:0] distance;
      logic signed [OUT_BITS-1:0] bary_u;
      logic signed [OUT_BITS-1:0] bary_v;
   } rsp_type;

   // Per request control travelling beside the arithmetic
   typedef struct packed {
      logic skip;
      logic quad;
   } side_type;

   // Saturated quotient and a flag for a zero divisor
   typedef struct packed {
      logic                       zero;
      logic signed [OUT_BITS-1:0] value;
   } quo_type;

endpackage
`default_nettype wire

// ----- src/rtqi_front.sv -----
// Front stages: unpack coordinates, edge vectors, cross products.
`default_nettype none
module rtqi_front #(
   parameter int COORD_BITS = rtqi_pkg::COORD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           adv,
   input  rtqi_pkg::req_type              req,
   output logic signed [COORD_BITS:0]     m_o   [3],
   output logic signed [COORD_BITS:0]     t0_o  [3],
   output logic signed [COORD_BITS:0]     t1_o  [3],
   output logic signed [COORD_BITS:0]     t2_o  [3],
   output logic signed [COORD_BITS-1:0]   r_o   [3],
   output logic signed [2*COORD_BITS+1:0] x_o   [3],
   output logic signed [2*COORD_BITS+2:0] cra_o [3],
   output logic signed [2*COORD_BITS+2:0] crb_o [3]
);
   import rtqi_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int D  = C + 1;
   localparam int XP = 2*C + 1;
   localparam int CP = 2*C + 2;
   localparam int XW = 2*C + 2;
   localparam int CW = 2*C + 3;
   localparam int NXT [3] = '{1, 2, 0};
   localparam int PRV [3] = '{2, 0, 1};

   logic signed [C-1:0]  s_u [3];
   logic signed [C-1:0]  r_u [3];
   logic signed [C-1:0]  a_u [3];
   logic signed [C-1:0]  b_u [3];
   logic signed [C-1:0]  c_u [3];
   logic signed [C-1:0]  d_u [3];
   logic signed [C-1:0]  p3  [3];
   logic signed [D-1:0]  t0_in [3];
   logic signed [D-1:0]  t1_in [3];
   logic signed [D-1:0]  t2_in [3];
   logic signed [D-1:0]  m_in  [3];

   logic signed [D-1:0]  t0_ff [0:2][3];
   logic signed [D-1:0]  t1_ff [0:2][3];
   logic signed [D-1:0]  t2_ff [0:2][3];
   logic signed [D-1:0]  m_ff  [0:2][3];
   logic signed [C-1:0]  r_ff  [0:2][3];

   logic signed [XP-1:0] xpa_in [3];
   logic signed [XP-1:0] xpb_in [3];
   logic signed [CP-1:0] caa_in [3];
   logic signed [CP-1:0] cab_in [3];
   logic signed [CP-1:0] cba_in [3];
   logic signed [CP-1:0] cbb_in [3];
   logic signed [XP-1:0] xpa_ff [3];
   logic signed [XP-1:0] xpb_ff [3];
   logic signed [CP-1:0] caa_ff [3];
   logic signed [CP-1:0] cab_ff [3];
   logic signed [CP-1:0] cba_ff [3];
   logic signed [CP-1:0] cbb_ff [3];

   logic signed [XW-1:0] x_in   [3];
   logic signed [CW-1:0] cra_in [3];
   logic signed [CW-1:0] crb_in [3];
   logic signed [XW-1:0] x_ff   [3];
   logic signed [CW-1:0] cra_ff [3];
   logic signed [CW-1:0] crb_ff [3];

   // Unpack lanes and form edge vectors from the shared corner
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s_u[k]   = $signed(req.ray_start[k*C +: C]);
         r_u[k]   = $signed(req.ray_dir[k*C +: C]);
         a_u[k]   = $signed(req.vertex_a[k*C +: C]);
         b_u[k]   = $signed(req.vertex_b[k*C +: C]);
         c_u[k]   = $signed(req.vertex_c[k*C +: C]);
         d_u[k]   = $signed(req.vertex_d[k*C +: C]);
         p3[k]    = req.is_quad ? d_u[k] : c_u[k];
         t0_in[k] = D'(p3[k]) - D'(a_u[k]);
         t1_in[k] = D'(p3[k]) - D'(b_u[k]);
         t2_in[k] = D'(p3[k]) - D'(c_u[k]);
         m_in[k]  = D'(s_u[k]) - D'(p3[k]);
      end
   end

   // Partial products of the three cross products
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         xpa_in[k] = t1_ff[0][PRV[k]] * r_ff[0][NXT[k]];
         xpb_in[k] = t1_ff[0][NXT[k]] * r_ff[0][PRV[k]];
         caa_in[k] = m_ff[0][NXT[k]] * t0_ff[0][PRV[k]];
         cab_in[k] = m_ff[0][PRV[k]] * t0_ff[0][NXT[k]];
         cba_in[k] = m_ff[0][NXT[k]] * t2_ff[0][PRV[k]];
         cbb_in[k] = m_ff[0][PRV[k]] * t2_ff[0][NXT[k]];
      end
   end

   // Close the cross products
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         x_in[k]   = XW'(xpa_ff[k]) - XW'(xpb_ff[k]);
         cra_in[k] = CW'(caa_ff[k]) - CW'(cab_ff[k]);
         crb_in[k] = CW'(cba_ff[k]) - CW'(cbb_ff[k]);
      end
   end

   // Advance all three stages together
   always_ff @(posedge clock) begin
      if (adv) begin
         t0_ff[0] <= t0_in;
         t1_ff[0] <= t1_in;
         t2_ff[0] <= t2_in;
         m_ff[0]  <= m_in;
         r_ff[0]  <= r_u;
         for (int i = 1; i < 3; i++) begin
            t0_ff[i] <= t0_ff[i-1];
            t1_ff[i] <= t1_ff[i-1];
            t2_ff[i] <= t2_ff[i-1];
            m_ff[i]  <= m_ff[i-1];
            r_ff[i]  <= r_ff[i-1];
         end
         xpa_ff <= xpa_in;
         xpb_ff <= xpb_in;
         caa_ff <= caa_in;
         cab_ff <= cab_in;
         cba_ff <= cba_in;
         cbb_ff <= cbb_in;
         x_ff   <= x_in;
         cra_ff <= cra_in;
         crb_ff <= crb_in;
      end
   end

   assign m_o   = m_ff[2];
   assign t0_o  = t0_ff[2];
   assign t1_o  = t1_ff[2];
   assign t2_o  = t2_ff[2];
   assign r_o   = r_ff[2];
   assign x_o   = x_ff;
   assign cra_o = cra_ff;
   assign crb_o = crb_ff;

endmodule
`default_nettype wire

// ----- src/rtqi_dot.sv -----
// Three-term dot product with the wide operand split in halves over three stages.
`default_nettype none
module rtqi_dot #(
   parameter int A_BITS   = rtqi_pkg::COORD_BITS_DEF + 1,
   parameter int B_BITS   = 2*rtqi_pkg::COORD_BITS_DEF + 2,
   parameter int SUM_BITS = 3*rtqi_pkg::COORD_BITS_DEF + 6
) (
   input  logic                       clock,
   input  logic                       adv,
   input  logic signed [A_BITS-1:0]   a_i [3],
   input  logic signed [B_BITS-1:0]   b_i [3],
   output logic signed [SUM_BITS-1:0] dot_o
);
   import rtqi_pkg::*;

   localparam int SPL = B_BITS / 2;
   localparam int LOP = A_BITS + SPL + 1;
   localparam int HIP = A_BITS + B_BITS - SPL;

   logic signed [LOP-1:0]      lo_in   [3];
   logic signed [HIP-1:0]      hi_in   [3];
   logic signed [LOP-1:0]      lo_ff   [3];
   logic signed [HIP-1:0]      hi_ff   [3];
   logic signed [SUM_BITS-1:0] term_in [3];
   logic signed [SUM_BITS-1:0] term_ff [3];
   logic signed [SUM_BITS-1:0] sum_in;
   logic signed [SUM_BITS-1:0] sum_ff;

   // Low half unsigned, high half signed
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lo_in[k]   = a_i[k] * $signed({1'b0, b_i[k][SPL-1:0]});
         hi_in[k]   = a_i[k] * $signed(b_i[k][B_BITS-1:SPL]);
         term_in[k] = (SUM_BITS'(hi_ff[k]) <<< SPL) + SUM_BITS'(lo_ff[k]);
      end
      sum_in = term_ff[0] + term_ff[1] + term_ff[2];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         term_ff <= term_in;
         sum_ff  <= sum_in;
      end
   end

   assign dot_o = sum_ff;

endmodule
`default_nettype wire

// ----- src/rtqi_div.sv -----
// Pipelined restoring divider: num * 2^frac / den, truncated, saturated to the result width.
`default_nettype none
module rtqi_div #(
   parameter int SUM_BITS  = 3*rtqi_pkg::COORD_BITS_DEF + 6,
   parameter int FRAC_BITS = rtqi_pkg::RESULT_FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       adv,
   input  logic signed [SUM_BITS-1:0] num_i,
   input  logic signed [SUM_BITS-1:0] den_i,
   output rtqi_pkg::quo_type          quo_o
);
   import rtqi_pkg::*;

   localparam int QB  = OUT_BITS;
   localparam int RW  = SUM_BITS + QB;
   localparam int CWD = SUM_BITS + FRAC_BITS + QB;
   localparam logic [QB-1:0] HALF = {1'b1, {(QB-1){1'b0}}};
   localparam logic [QB-1:0] MAXP = {1'b0, {(QB-1){1'b1}}};

   typedef struct packed {
      logic neg;
      logic zero;
      logic ovf;
   } div_ctl_type;

   logic [SUM_BITS-1:0] n_ff;
   logic [SUM_BITS-1:0] d0_ff;
   div_ctl_type         ctl0_ff;
   logic [SUM_BITS-1:0] n_abs;
   logic [SUM_BITS-1:0] d_abs;
   logic [CWD-1:0]      n_sh;
   logic [CWD-1:0]      d_sh;

   logic [RW-1:0]       rem_ff [0:QB];
   logic [QB-1:0]       q_ff   [0:QB];
   logic [SUM_BITS-1:0] dd_ff  [0:QB];
   div_ctl_type         ctl_ff [0:QB];
   logic [RW-1:0]       rem_in [0:QB-1];
   logic [QB-1:0]       q_in   [0:QB-1];
   logic [RW-1:0]       trial  [0:QB-1];
   logic                ge     [0:QB-1];

   logic signed [QB:0]  q_neg;
   quo_type             quo_in;
   quo_type             quo_ff;

   // Magnitudes and the divisor check
   always_comb begin
      n_abs = num_i[SUM_BITS-1] ? SUM_BITS'(-num_i) : SUM_BITS'(num_i);
      d_abs = den_i[SUM_BITS-1] ? SUM_BITS'(-den_i) : SUM_BITS'(den_i);
      n_sh  = CWD'(n_ff) << FRAC_BITS;
      d_sh  = CWD'(d0_ff) << QB;
   end

   // One quotient bit per stage, most significant first
   always_comb begin
      for (int j = 0; j < QB; j++) begin
         trial[j]  = RW'(dd_ff[j]) << (QB - 1 - j);
         ge[j]     = rem_ff[j] >= trial[j];
         rem_in[j] = ge[j] ? rem_ff[j] - trial[j] : rem_ff[j];
         q_in[j]   = {q_ff[j][QB-2:0], ge[j]};
      end
   end

   // Apply sign and saturate
   always_comb begin
      q_neg        = -$signed({1'b0, q_ff[QB]});
      quo_in.zero  = ctl_ff[QB].zero;
      if (ctl_ff[QB].neg) begin
         if (ctl_ff[QB].ovf || q_ff[QB] > HALF) begin
            quo_in.value = $signed(HALF);
         end else begin
            quo_in.value = q_neg[QB-1:0];
         end
      end else begin
         if (ctl_ff[QB].ovf || q_ff[QB] > MAXP) begin
            quo_in.value = $signed(MAXP);
         end else begin
            quo_in.value = $signed(q_ff[QB]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n_ff         <= n_abs;
         d0_ff        <= d_abs;
         ctl0_ff.neg  <= num_i[SUM_BITS-1] ^ den_i[SUM_BITS-1];
         ctl0_ff.zero <= (den_i == '0);
         ctl0_ff.ovf  <= 1'b0;
         rem_ff[0]    <= n_sh[RW-1:0];
         q_ff[0]      <= '0;
         dd_ff[0]     <= d0_ff;
         ctl_ff[0]    <= '{neg: ctl0_ff.neg, zero: ctl0_ff.zero, ovf: (n_sh >= d_sh)};
         for (int j = 0; j < QB; j++) begin
            rem_ff[j+1] <= rem_in[j];
            q_ff[j+1]   <= q_in[j];
            dd_ff[j+1]  <= dd_ff[j];
            ctl_ff[j+1] <= ctl_ff[j];
         end
         quo_ff <= quo_in;
      end
   end

   assign quo_o = quo_ff;

endmodule
`default_nettype wire

// ----- src/rtqi_pick.sv -----
// Tolerance windows of both halves, hit selection and the output register.
`default_nettype none
module rtqi_pick #(
   parameter int FRAC_BITS = rtqi_pkg::RESULT_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic [rtqi_pkg::EPS_BITS-1:0]   eps_i,
   input  logic                            vld_i,
   input  rtqi_pkg::side_type              side_i,
   input  rtqi_pkg::quo_type               ua_i,
   input  rtqi_pkg::quo_type               va_i,
   input  rtqi_pkg::quo_type               la_i,
   input  rtqi_pkg::quo_type               ub_i,
   input  rtqi_pkg::quo_type               vb_i,
   input  rtqi_pkg::quo_type               lb_i,
   output logic                            rsp_valid,
   output rtqi_pkg::rsp_type               rsp_payload
);
   import rtqi_pkg::*;

   localparam int WW = ((FRAC_BITS > OUT_BITS) ? FRAC_BITS : OUT_BITS) + 3;
   localparam logic signed [WW-1:0] ONE = WW'(1) << FRAC_BITS;

   logic signed [WW-1:0] eps_w;
   logic                 ok_a;
   logic                 ok_b;
   rsp_type              rsp_in;
   rsp_type              rsp_ff;
   logic                 valid_ff;

   function automatic logic half_ok(quo_type u, quo_type v, quo_type l,
                                    logic signed [WW-1:0] eps);
      logic signed [WW-1:0] uw;
      logic signed [WW-1:0] vw;
      logic signed [WW-1:0] lw;
      uw = WW'(u.value);
      vw = WW'(v.value);
      lw = WW'(l.value);
      return !u.zero && (uw < eps) && (uw > -(ONE + eps)) && (vw < eps)
             && ((uw + vw) > -(ONE + eps)) && (lw > -eps) && (lw < (ONE + eps));
   endfunction

   // Choose the first half that hits, zero the fields otherwise
   always_comb begin
      eps_w  = $signed(WW'(eps_i));
      ok_a   = half_ok(ua_i, va_i, la_i, eps_w);
      ok_b   = half_ok(ub_i, vb_i, lb_i, eps_w);
      rsp_in = '{hit_kind: KIND_NONE, distance: '0, bary_u: '0, bary_v: '0};
      if (!side_i.skip) begin
         if (ok_a) begin
            rsp_in = '{hit_kind: KIND_FIRST, distance: la_i.value,
                       bary_u: ua_i.value, bary_v: va_i.value};
         end else if (side_i.quad && ok_b) begin
            rsp_in = '{hit_kind: KIND_SECOND, distance: lb_i.value,
                       bary_u: ub_i.value, bary_v: vb_i.value};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= vld_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

// ----- src/ray_triangle_quad_intersect.sv -----
// Top level: ray segment against triangle or quad face, fixed point Cramer's rule pipeline.
//
//   port group | dir | handshake            | payload
//   req_       | in  | req_valid/req_ready  | req_payload (rtqi_pkg::req_type)
//   rsp_       | out | rsp_valid/rsp_ready  | rsp_payload (rtqi_pkg::rsp_type)
//   csr_       | in  | csr_valid/csr_ready  | csr_data, tolerance (Q.frac)
//
// One request enters per cycle unless a waiting result holds the pipeline; each result passes through the
// cross products, split dot products, one quotient bit per divider stage and the output register.
// Reset clears the valid bits and loads the tolerance with 1; csr_ready is always high.
// While a result waits with rsp_ready low the whole pipeline holds, so req_ready drops too.
`default_nettype none
module ray_triangle_quad_intersect #(
   parameter int COORD_BITS       = rtqi_pkg::COORD_BITS_DEF,
   parameter int RESULT_FRAC_BITS = rtqi_pkg::RESULT_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  rtqi_pkg::req_type             req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output rtqi_pkg::rsp_type             rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rtqi_pkg::EPS_BITS-1:0] csr_data
);
   import rtqi_pkg::*;

   localparam int C        = COORD_BITS;
   localparam int D        = C + 1;
   localparam int XW       = 2*C + 2;
   localparam int CW       = 2*C + 3;
   localparam int SUM_BITS = 3*C + 6;
   localparam int PRE      = FRONT_LAT + DOT_LAT + DIV_LAT;

   logic                adv;
   logic [EPS_BITS-1:0] eps_ff;
   logic                vld_ff  [0:PRE-1];
   side_type            side_ff [0:PRE-1];
   side_type            side_in;

   logic signed [D-1:0]        m_w   [3];
   logic signed [D-1:0]        t0_w  [3];
   logic signed [D-1:0]        t1_w  [3];
   logic signed [D-1:0]        t2_w  [3];
   logic signed [C-1:0]        r_w   [3];
   logic signed [XW-1:0]       x_w   [3];
   logic signed [CW-1:0]       cra_w [3];
   logic signed [CW-1:0]       crb_w [3];
   logic signed [SUM_BITS-1:0] det1;
   logic signed [SUM_BITS-1:0] det_a;
   logic signed [SUM_BITS-1:0] det_b;
   logic signed [SUM_BITS-1:0] numv_a;
   logic signed [SUM_BITS-1:0] numl_a;
   logic signed [SUM_BITS-1:0] numv_b;
   logic signed [SUM_BITS-1:0] numl_b;
   quo_type                    ua;
   quo_type                    va;
   quo_type                    la;
   quo_type                    ub;
   quo_type                    vb;
   quo_type                    lb;

   // Hold everything while a result waits
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   // Tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
      end else if (csr_valid) begin
         eps_ff <= csr_data;
      end
   end

   // Drop the test for the face the ray left
   always_comb begin
      side_in.skip = (req_payload.origin_object == req_payload.face_object)
                     && (req_payload.origin_face == req_payload.face_handle);
      side_in.quad = req_payload.is_quad;
   end

   // Valid bits and side control beside the arithmetic
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PRE; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < PRE; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < PRE; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   rtqi_front #(.COORD_BITS(C)) u_front (
      .clock (clock), .adv (adv), .req (req_payload),
      .m_o (m_w), .t0_o (t0_w), .t1_o (t1_w), .t2_o (t2_w), .r_o (r_w),
      .x_o (x_w), .cra_o (cra_w), .crb_o (crb_w)
   );

   rtqi_dot #(.A_BITS(D), .B_BITS(XW), .SUM_BITS(SUM_BITS)) u_det1 (
      .clock (clock), .adv (adv), .a_i (m_w), .b_i (x_w), .dot_o (det1)
   );
   rtqi_dot #(.A_BITS(D), .B_BITS(XW), .SUM_BITS(SUM_BITS)) u_det_a (
      .clock (clock), .adv (adv), .a_i (t0_w), .b_i (x_w), .dot_o (det_a)
   );
   rtqi_dot #(.A_BITS(D), .B_BITS(XW), .SUM_BITS(SUM_BITS)) u_det_b (
      .clock (clock), .adv (adv), .a_i (t2_w), .b_i (x_w), .dot_o (det_b)
   );
   rtqi_dot #(.A_BITS(C), .B_BITS(CW), .SUM_BITS(SUM_BITS)) u_numv_a (
      .clock (clock), .adv (adv), .a_i (r_w), .b_i (cra_w), .dot_o (numv_a)
   );
   rtqi_dot #(.A_BITS(D), .B_BITS(CW), .SUM_BITS(SUM_BITS)) u_numl_a (
      .clock (clock), .adv (adv), .a_i (t1_w), .b_i (cra_w), .dot_o (numl_a)
   );
   rtqi_dot #(.A_BITS(C), .B_BITS(CW), .SUM_BITS(SUM_BITS)) u_numv_b (
      .clock (clock), .adv (adv), .a_i (r_w), .b_i (crb_w), .dot_o (numv_b)
   );
   rtqi_dot #(.A_BITS(D), .B_BITS(CW), .SUM_BITS(SUM_BITS)) u_numl_b (
      .clock (clock), .adv (adv), .a_i (t1_w), .b_i (crb_w), .dot_o (numl_b)
   );

   rtqi_div #(.SUM_BITS(SUM_BITS), .FRAC_BITS(RESULT_FRAC_BITS)) u_div_ua (
      .clock (clock), .adv (adv), .num_i (det1), .den_i (det_a), .quo_o (ua)
   );
   rtqi_div #(.SUM_BITS(SUM_BITS), .FRAC_BITS(RESULT_FRAC_BITS)) u_div_va (
      .clock (clock), .adv (adv), .num_i (numv_a), .den_i (det_a), .quo_o (va)
   );
   rtqi_div #(.SUM_BITS(SUM_BITS), .FRAC_BITS(RESULT_FRAC_BITS)) u_div_la (
      .clock (clock), .adv (adv), .num_i (numl_a), .den_i (det_a), .quo_o (la)
   );
   rtqi_div #(.SUM_BITS(SUM_BITS), .FRAC_BITS(RESULT_FRAC_BITS)) u_div_ub (
      .clock (clock), .adv (adv), .num_i (det1), .den_i (det_b), .quo_o (ub)
   );
   rtqi_div #(.SUM_BITS(SUM_BITS), .FRAC_BITS(RESULT_FRAC_BITS)) u_div_vb (
      .clock (clock), .adv (adv), .num_i (numv_b), .den_i (det_b), .quo_o (vb)
   );
   rtqi_div #(.SUM_BITS(SUM_BITS), .FRAC_BITS(RESULT_FRAC_BITS)) u_div_lb (
      .clock (clock), .adv (adv), .num_i (numl_b), .den_i (det_b), .quo_o (lb)
   );

   rtqi_pick #(.FRAC_BITS(RESULT_FRAC_BITS)) u_pick (
      .clock (clock), .reset (reset), .adv (adv), .eps_i (eps_ff),
      .vld_i (vld_ff[PRE-1]), .side_i (side_ff[PRE-1]),
      .ua_i (ua), .va_i (va), .la_i (la), .ub_i (ub), .vb_i (vb), .lb_i (lb),
      .rsp_valid (rsp_valid), .rsp_payload (rsp_payload)
   );

   // A miss carries zero fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.hit_kind == KIND_NONE |->
         rsp_payload.distance == '0 && rsp_payload.bary_u == '0 && rsp_payload.bary_v == '0)
      else $error("miss with nonzero fields");

   // Second half hits only for quads
   assert property (@(posedge clock) disable iff (reset)
      adv && vld_ff[PRE-1] && !side_ff[PRE-1].quad |=> rsp_payload.hit_kind != KIND_SECOND)
      else $error("second half hit on a triangle");

   // The origin face never hits
   assert property (@(posedge clock) disable iff (reset)
      adv && vld_ff[PRE-1] && side_ff[PRE-1].skip |=> rsp_payload.hit_kind == KIND_NONE)
      else $error("hit on the origin face");

endmodule
`default_nettype wire
